@@ rtl/dqz_pkg.sv @@
`default_nettype none

package dqz_pkg;

	// Fixed formats of the sample path
	localparam int SAMPLE_W      = 32;
	localparam int ERR_W         = 32;
	localparam int OUTPUT_BITS   = 16;
	localparam int FRACTION_BITS = 28;
	localparam int SCALE_SHIFT   = FRACTION_BITS + 1 - OUTPUT_BITS;
	localparam int CLIP_W        = FRACTION_BITS + 1;
	localparam int SUM_W         = SAMPLE_W + 4;
	localparam int SEED_W        = 32;

	typedef logic signed [SAMPLE_W-1:0]    sample_t;
	typedef logic signed [OUTPUT_BITS-1:0] pcm_t;
	typedef logic signed [SUM_W-1:0]       sum_t;
	typedef logic signed [CLIP_W-1:0]      clip_t;
	typedef logic signed [ERR_W-1:0]       err_t;
	typedef logic [SEED_W-1:0]             seed_t;

	// Clip bounds [-1, 1 - 1 LSB] and rounding bias
	localparam sum_t CLIP_HI  = sum_t'((longint'(1) <<< FRACTION_BITS) - longint'(1));
	localparam sum_t CLIP_LO  = sum_t'(-(longint'(1) <<< FRACTION_BITS));
	localparam sum_t HALF_LSB = sum_t'(longint'(1) <<< (SCALE_SHIFT - 1));

	// Noise generator coefficients
	localparam seed_t LCG_MUL  = 32'h0019660d;
	localparam seed_t LCG_ADD  = 32'h3c6ef35f;
	localparam seed_t SEED_RST = 32'h0;

	// Register map
	localparam logic REG_DITHER_MODE = 1'b0;
	localparam logic REG_MONO        = 1'b1;
	localparam int   PADDR_W         = 3;
	localparam int   PDATA_W         = 32;

	// Per-lane control word
	typedef struct packed {
		logic dither;
		logic advance;
	} lane_ctrl_t;

	function automatic clip_t clip_sample(sum_t v);
		clip_t r;
		if (v > CLIP_HI) begin
			r = clip_t'(CLIP_HI);
		end else if (v < CLIP_LO) begin
			r = clip_t'(CLIP_LO);
		end else begin
			r = clip_t'(v);
		end
		return r;
	endfunction

	function automatic seed_t next_seed(seed_t s);
		logic [2*SEED_W-1:0] p;
		p = {{SEED_W{1'b0}}, s} * {{SEED_W{1'b0}}, LCG_MUL};
		return p[SEED_W-1:0] + LCG_ADD;
	endfunction

endpackage

`default_nettype wire

@@ rtl/dqz_in_if.sv @@
`default_nettype none

interface dqz_in_if;
	logic             valid;
	logic             ready;
	dqz_pkg::sample_t left_sample;
	dqz_pkg::sample_t right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

`default_nettype wire

@@ rtl/dqz_out_if.sv @@
`default_nettype none

interface dqz_out_if;
	logic          valid;
	logic          ready;
	dqz_pkg::pcm_t left_pcm;
	dqz_pkg::pcm_t right_pcm;

	modport source (output valid, output left_pcm, output right_pcm, input ready);
	modport sink   (input valid, input left_pcm, input right_pcm, output ready);
endinterface

`default_nettype wire

@@ rtl/dither_quantizer_16bit_unit.sv @@
`default_nettype none
// Result words are registered in the output stage of the merge buffer.
// Throughput: one stereo frame per cycle while that buffer is not full; the error
// feedback and noise state of each channel lane close with no pipeline stage, and
// the two-deep output buffer takes a further frame while the output is stalled.
// Reset (arst_n low, asynchronous): registers, feedback errors and buffer clear; seeds reload.

module dither_quantizer_16bit_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [dqz_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [dqz_pkg::PDATA_W-1:0]  pwdata,
	output logic      [dqz_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready,
	dqz_in_if.sink                            frame,
	dqz_out_if.source                         pcm
);
	import dqz_pkg::*;

	logic       dither_q, mono_q;
	logic       wr_en;
	logic       push;
	logic       buf_ready;
	lane_ctrl_t ctrl_l, ctrl_r;
	pcm_t       q_l, q_r;

	// Register port
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dither_q <= 1'b0;
			mono_q   <= 1'b0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_DITHER_MODE: dither_q <= pwdata[0];
				REG_MONO:        mono_q   <= pwdata[0];
				default:         dither_q <= dither_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_DITHER_MODE: prdata = {{(PDATA_W-1){1'b0}}, dither_q};
			REG_MONO:        prdata = {{(PDATA_W-1){1'b0}}, mono_q};
			default:         prdata = '0;
		endcase
	end

	// Accept a frame and steer the lanes
	assign frame.ready = buf_ready;
	assign push        = frame.valid & buf_ready;

	always_comb begin
		ctrl_l.dither  = dither_q;
		ctrl_l.advance = push & dither_q;
		ctrl_r.dither  = dither_q;
		ctrl_r.advance = push & dither_q & !mono_q;
	end

	dqz_lane u_lane_l (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl_l),
		.x      (frame.left_sample),
		.q      (q_l)
	);

	dqz_lane u_lane_r (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl_r),
		.x      (frame.right_sample),
		.q      (q_r)
	);

	dqz_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.mono    (mono_q),
		.left_q  (q_l),
		.right_q (q_r),
		.ready   (buf_ready),
		.pcm     (pcm)
	);

endmodule

`default_nettype wire

@@ rtl/dqz_lane.sv @@
`default_nettype none

module dqz_lane (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dqz_pkg::lane_ctrl_t ctrl,
	input  wire dqz_pkg::sample_t    x,
	output dqz_pkg::pcm_t            q
);
	import dqz_pkg::*;

	err_t  now_q, prev_q, old_q;
	seed_t seed_q, fresh_q;

	sum_t                   shaping;
	sum_t                   base;
	sum_t                   out_sum;
	logic signed [SCALE_SHIFT:0] dith;
	clip_t                  samp_clip, out_clip;
	logic signed [CLIP_W:0] err_full;
	err_t                   err_next;
	err_t                   half_now;

	// Three-tap error feedback, only in dither mode
	always_comb begin
		shaping = sum_t'(now_q) - sum_t'(prev_q) + sum_t'(old_q);
		base    = sum_t'(x) + (ctrl.dither ? shaping : sum_t'(0));
	end

	// Rectangular-difference dither from the new and old generator words
	assign dith = $signed({1'b0, fresh_q[SCALE_SHIFT-1:0]})
		- $signed({1'b0, seed_q[SCALE_SHIFT-1:0]});

	// Bias, dither, clip and drop the low bits
	always_comb begin
		out_sum   = base + HALF_LSB + (ctrl.dither ? sum_t'(dith) : sum_t'(0));
		out_clip  = clip_sample(out_sum);
		samp_clip = clip_sample(base);
		q         = out_clip[CLIP_W-1:SCALE_SHIFT];
	end

	// Quantization error and truncating halving
	always_comb begin
		err_full = {samp_clip[CLIP_W-1], samp_clip}
			- {out_clip[CLIP_W-1], out_clip[CLIP_W-1:SCALE_SHIFT], {SCALE_SHIFT{1'b0}}};
		err_next = err_t'(err_full);
		half_now = (now_q + err_t'(now_q[ERR_W-1])) >>> 1;
	end

	// Advance the lane state when ctrl.advance marks a dithered word; fresh_q runs one step ahead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q   <= '0;
			prev_q  <= '0;
			old_q   <= '0;
			seed_q  <= SEED_RST;
			fresh_q <= next_seed(SEED_RST);
		end else if (ctrl.advance) begin
			now_q   <= err_next;
			prev_q  <= half_now;
			old_q   <= prev_q;
			seed_q  <= fresh_q;
			fresh_q <= next_seed(fresh_q);
		end
	end

	a_fresh_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q == next_seed(seed_q))
		else $error("lookahead generator word out of step");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.advance |=> $stable(seed_q) && $stable(now_q) && $stable(prev_q))
		else $error("lane state moved without an advance");

	a_adv_dither: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.advance |-> ctrl.dither)
		else $error("lane state advanced in round mode");

endmodule

`default_nettype wire

@@ rtl/dqz_merge.sv @@
`default_nettype none

module dqz_merge (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic          mono,
	input  wire dqz_pkg::pcm_t left_q,
	input  wire dqz_pkg::pcm_t right_q,
	output logic               ready,
	dqz_out_if.source          pcm
);
	import dqz_pkg::*;

	logic out_vld_q, skid_vld_q;
	pcm_t out_l_q, out_r_q, skid_l_q, skid_r_q;
	pcm_t sel_r;
	logic pop;

	// Duplicate the left word in mono
	assign sel_r = mono ? left_q : right_q;
	assign pop   = out_vld_q & pcm.ready;
	assign ready = !skid_vld_q;

	// Control of the two-deep output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || pop) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	// Payload of the buffer
	always_ff @(posedge clk) begin
		if (!out_vld_q || pop) begin
			if (skid_vld_q) begin
				out_l_q <= skid_l_q;
				out_r_q <= skid_r_q;
			end else if (push) begin
				out_l_q <= left_q;
				out_r_q <= sel_r;
			end
		end else if (push) begin
			skid_l_q <= left_q;
			skid_r_q <= sel_r;
		end
	end

	assign pcm.valid     = out_vld_q;
	assign pcm.left_pcm  = out_l_q;
	assign pcm.right_pcm = out_r_q;

	a_skid_behind: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid word held with empty output stage");

	a_stall_park: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !pcm.ready && push |=> skid_vld_q)
		else $error("word taken during stall was not parked");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> !push)
		else $error("word accepted with full buffer");

endmodule

`default_nettype wire

@@ test/dither_quantizer_16bit_unit_test.sv @@
`timescale 1ns / 100ps

module dither_quantizer_16bit_unit_test;
	import dqz_pkg::*;

	localparam longint FULL_POS      = (longint'(1) <<< FRACTION_BITS) - 1;
	localparam longint FULL_NEG      = -(longint'(1) <<< FRACTION_BITS);
	localparam longint ROUND_BIAS    = longint'(1) <<< (FRACTION_BITS - OUTPUT_BITS);
	localparam longint NOISE_MASK    = (longint'(1) <<< SCALE_SHIFT) - 1;
	localparam int     RANDOM_FRAMES = 1600;

	typedef struct packed {
		pcm_t left;
		pcm_t right;
	} pcm_pair_t;

	// One directed frame: settings, samples, and a typed result where obvious
	typedef struct packed {
		logic    dither;
		logic    mono;
		sample_t left;
		sample_t right;
		logic    typed;
		pcm_t    left_pcm;
		pcm_t    right_pcm;
	} frame_row_t;

	localparam frame_row_t DIRECTED_ROWS [21] = '{
		// round, stereo: zero, saturation, clip edges, half-LSB boundaries
		'{1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1, 16'h0000, 16'h0000},
		'{1'b0, 1'b0, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 16'h7fff, 16'h8000},
		'{1'b0, 1'b0, 32'h0fff_ffff, 32'hf000_0000, 1'b1, 16'h7fff, 16'h8000},
		'{1'b0, 1'b0, 32'h1000_0000, 32'hefff_ffff, 1'b1, 16'h7fff, 16'h8000},
		'{1'b0, 1'b0, 32'h0000_1000, 32'h0000_0fff, 1'b1, 16'h0001, 16'h0000},
		'{1'b0, 1'b0, 32'hffff_f000, 32'hffff_efff, 1'b1, 16'h0000, 16'hffff},
		'{1'b0, 1'b0, 32'h0000_2000, 32'hffff_e000, 1'b1, 16'h0001, 16'hffff},
		'{1'b0, 1'b0, 32'h0012_3456, 32'hfedc_ba98, 1'b0, 16'h0000, 16'h0000},
		// round, mono: right input ignored
		'{1'b0, 1'b1, 32'h0000_2000, 32'h7fff_ffff, 1'b1, 16'h0001, 16'h0001},
		'{1'b0, 1'b1, 32'h8000_0000, 32'h0000_0000, 1'b1, 16'h8000, 16'h8000},
		// dither, stereo: saturation, shaped frames, then saturation again
		'{1'b1, 1'b0, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 16'h7fff, 16'h8000},
		'{1'b1, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'h0000, 16'h0000},
		'{1'b1, 1'b0, 32'h0012_3456, 32'hff87_6543, 1'b0, 16'h0000, 16'h0000},
		'{1'b1, 1'b0, 32'h0000_0fff, 32'hffff_f001, 1'b0, 16'h0000, 16'h0000},
		'{1'b1, 1'b0, 32'h0aaa_aaaa, 32'hf555_5555, 1'b0, 16'h0000, 16'h0000},
		'{1'b1, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 16'h8000, 16'h7fff},
		// dither, mono: only the left lane advances
		'{1'b1, 1'b1, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 16'h7fff, 16'h7fff},
		'{1'b1, 1'b1, 32'h0100_0000, 32'h0000_0000, 1'b0, 16'h0000, 16'h0000},
		'{1'b1, 1'b1, 32'hfe00_0000, 32'h1234_5678, 1'b0, 16'h0000, 16'h0000},
		'{1'b1, 1'b1, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 16'h8000, 16'h8000},
		// back to round, stereo
		'{1'b0, 1'b0, 32'h0c00_0000, 32'hf400_0000, 1'b0, 16'h0000, 16'h0000}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	dqz_in_if  frame_bus ();
	dqz_out_if pcm_bus ();

	dither_quantizer_16bit_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.frame   (frame_bus),
		.pcm     (pcm_bus)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard stop if the block hangs
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Shadow of the block: settings and per-lane shaping state
	logic      cfg_dither = 1'b0;
	logic      cfg_mono = 1'b0;
	longint    err_now [2] = '{0, 0};
	longint    err_prev [2] = '{0, 0};
	longint    err_old [2] = '{0, 0};
	seed_t     noise_state [2] = '{32'h0, 32'h0};

	pcm_pair_t pcm_expected [$];
	int        mismatch_count = 0;
	int        results_checked = 0;
	int        frames_sent = 0;
	int        reg_writes = 0;
	int        burst_left = 0;
	logic      steady = 1'b0;

	function automatic longint clamp_full_scale(longint v);
		if (v > FULL_POS) return FULL_POS;
		if (v < FULL_NEG) return FULL_NEG;
		return v;
	endfunction

	function automatic pcm_t round_lane(sample_t x);
		longint s;
		s = clamp_full_scale(longint'(x) + ROUND_BIAS);
		return pcm_t'(s >>> SCALE_SHIFT);
	endfunction

	// Three-tap error feedback plus rectangular-difference noise
	function automatic pcm_t dither_lane(sample_t x, int ch);
		longint acc;
		longint shaped;
		longint q;
		seed_t  fresh;
		acc = longint'(x) + err_now[ch] - err_prev[ch] + err_old[ch];
		err_old[ch] = err_prev[ch];
		err_prev[ch] = err_now[ch] / 2;
		fresh = noise_state[ch] * LCG_MUL + LCG_ADD;
		shaped = acc + (longint'(1) <<< (SCALE_SHIFT - 1))
			+ (longint'(fresh) & NOISE_MASK) - (longint'(noise_state[ch]) & NOISE_MASK);
		noise_state[ch] = fresh;
		shaped = clamp_full_scale(shaped);
		acc = clamp_full_scale(acc);
		q = shaped >>> SCALE_SHIFT;
		err_now[ch] = acc - (q <<< SCALE_SHIFT);
		return pcm_t'(q);
	endfunction

	function automatic pcm_pair_t quantize_frame(sample_t l, sample_t r);
		pcm_pair_t p;
		if (cfg_dither) begin
			p.left = dither_lane(l, 0);
			if (cfg_mono) p.right = p.left;
			else p.right = dither_lane(r, 1);
		end else begin
			p.left = round_lane(l);
			if (cfg_mono) p.right = p.left;
			else p.right = round_lane(r);
		end
		return p;
	endfunction

	// Mix of full-range noise, in-range audio, clip edges and rounding boundaries
	function automatic sample_t random_sample();
		longint v;
		case ($urandom_range(0, 9))
			0, 1: v = longint'($signed($urandom()));
			2, 3, 4, 5: v = longint'($urandom_range(0, 32'h1fff_ffff)) + FULL_NEG;
			6: v = (($urandom_range(0, 1) == 1) ? FULL_POS : FULL_NEG)
				+ longint'($urandom_range(0, 8192)) - 4096;
			7: v = longint'($urandom_range(0, 65535)) - 32768;
			8: begin
				case ($urandom_range(0, 2))
					0: v = 64'sh7fff_ffff;
					1: v = -64'sh8000_0000;
					default: v = 0;
				endcase
			end
			default: v = ((longint'($urandom_range(0, 65535)) - 32768) <<< SCALE_SHIFT)
				- ROUND_BIAS + longint'($urandom_range(0, 2)) - 1;
		endcase
		return sample_t'(v);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Receiver: stall pattern changes style after each random span
	int          stall_span = 0;
	int          stall_style = 0;
	logic [15:0] stall_tick = '0;

	always @(posedge clk) begin
		stall_tick <= stall_tick + 1'b1;
		if (stall_span == 0) begin
			stall_style <= $urandom_range(0, 3);
			stall_span <= $urandom_range(50, 300);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_style)
			0: pcm_bus.ready <= 1'b1;
			1: pcm_bus.ready <= ($urandom_range(0, 1) == 1);
			2: pcm_bus.ready <= (stall_tick[3:0] < 4'd11);
			default: pcm_bus.ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	// Compare every accepted output word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && pcm_bus.valid && pcm_bus.ready) begin
			if (pcm_expected.size() == 0) begin
				report_mismatch($sformatf("unexpected word left=%h right=%h",
					pcm_bus.left_pcm, pcm_bus.right_pcm));
			end else begin
				if (pcm_bus.left_pcm !== pcm_expected[0].left)
					report_mismatch($sformatf("word %0d left_pcm got %h want %h",
						results_checked, pcm_bus.left_pcm, pcm_expected[0].left));
				if (pcm_bus.right_pcm !== pcm_expected[0].right)
					report_mismatch($sformatf("word %0d right_pcm got %h want %h",
						results_checked, pcm_bus.right_pcm, pcm_expected[0].right));
				void'(pcm_expected.pop_front());
				results_checked++;
			end
		end
	end

	// Send one frame, with a random gap at the start of each burst unless steady is set
	task automatic send_frame(input sample_t l, input sample_t r, input logic typed,
			input pcm_t left_want, input pcm_t right_want);
		int        gap;
		pcm_pair_t p;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				frame_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		frame_bus.valid <= 1'b1;
		frame_bus.left_sample <= l;
		frame_bus.right_sample <= r;
		do @(posedge clk); while (!frame_bus.ready);
		p = quantize_frame(l, r);
		if (typed) p = '{left: left_want, right: right_want};
		pcm_expected.push_back(p);
		frames_sent++;
	endtask

	// Drop valid and wait until every predicted word has come out
	task automatic settle();
		frame_bus.valid <= 1'b0;
		while (pcm_expected.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Setup and access cycle; upper data bits are noise the block must drop
	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {31'($urandom() >> 1), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// Idle before the next transfer
		@(posedge clk);
		reg_writes++;
	endtask

	task automatic set_mode(input logic dither, input logic mono);
		settle();
		write_reg({REG_DITHER_MODE, 2'b00}, dither);
		write_reg({REG_MONO, 2'b00}, mono);
		cfg_dither = dither;
		cfg_mono = mono;
	endtask

	initial begin
		frame_row_t row;
		int         phase;
		int         phase_len;
		logic [1:0] combo;

		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		frame_bus.valid = 1'b0;
		frame_bus.left_sample = '0;
		frame_bus.right_sample = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed frames, switching settings between groups
		foreach (DIRECTED_ROWS[i]) begin
			row = DIRECTED_ROWS[i];
			if (row.dither != cfg_dither || row.mono != cfg_mono)
				set_mode(row.dither, row.mono);
			send_frame(row.left, row.right, row.typed, row.left_pcm, row.right_pcm);
		end

		// Random phases: all four settings first, then random ones
		phase = 0;
		while (frames_sent < RANDOM_FRAMES + $size(DIRECTED_ROWS)) begin
			combo = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
			set_mode(combo[1], combo[0]);
			steady = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(100, 220);
			repeat (phase_len)
				send_frame(random_sample(), random_sample(), 1'b0, '0, '0);
			phase++;
		end

		// Drain, then let the pipeline empty out
		frame_bus.valid <= 1'b0;
		while (pcm_expected.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d frames in %0d phases, %0d register writes, %0d words checked.",
			frames_sent, phase, reg_writes, results_checked);
		$display("Round and dither modes, stereo and mono, saturating and boundary samples.");
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
